[hdl/hfv_pkg.sv]
`default_nettype none
package hfv_pkg;

    localparam int NS      = 4;
    localparam int SW      = 2;
    localparam int PB      = 16;
    localparam int ACC_W   = 2 * PB + SW;
    localparam int G_W     = PB + ACC_W;
    localparam int SCALE_W = G_W + SW;
    localparam int BEST_W  = 2 * PB;
    localparam int M_W     = BEST_W + PB;
    localparam int SUM_W   = M_W + SW;
    localparam int ROW_W   = 64;
    localparam int CNT_W   = $clog2(PB);
    localparam int ADDR_W  = 6;
    localparam int HISTORY_DEPTH_DEF = 16;

    localparam logic [PB-1:0]    F_RESET     = PB'((1 << PB) / NS);
    localparam logic [ROW_W-1:0] TRANS_RESET = 64'h4000_4000_4000_4000;
    localparam logic [4:0]       LAG_RESET   = 5'd1;
    localparam logic [2:0]       REG_LAG     = 3'd4;

    typedef logic [NS-1:0][PB-1:0] t_vec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_LOAD,
        S_DIV,
        S_UPD,
        S_BT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic mul1;
        logic mul2;
        logic div_load;
        logic div_step;
    } t_lane_ctl;

    function automatic logic [SW-1:0] argmax(input t_vec v);
        logic [SW-1:0] b;
        b = '0;
        for (int j = 1; j < NS; j++) begin
            if (v[j] > v[b]) begin
                b = SW'(j);
            end
        end
        return b;
    endfunction

endpackage
`default_nettype wire

[hdl/hfv_ram.sv]
`default_nettype none
module hfv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hdl/hfv_div.sv]
`default_nettype none
module hfv_div #(
    parameter int W = 52
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_load,
    input  wire logic                 i_step,
    input  wire logic [W-1:0]         i_num,
    input  wire logic [W-1:0]         i_den,
    output logic [hfv_pkg::PB-1:0]    o_quot
);

    logic [W-1:0]           r_rem;
    logic [hfv_pkg::PB-1:0] r_q;
    logic                   r_sat;
    logic                   r_zero;
    logic [W:0]             w_rem2;
    logic [W:0]             w_diff;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_diff = w_rem2 - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= i_num;
            r_q    <= '0;
            r_sat  <= (i_num >= i_den);
            r_zero <= (i_den == '0);
        end else if (i_step) begin
            if (w_rem2 >= {1'b0, i_den}) begin
                r_rem <= w_diff[W-1:0];
                r_q   <= {r_q[hfv_pkg::PB-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2[W-1:0];
                r_q   <= {r_q[hfv_pkg::PB-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_zero ? '0 : (r_sat ? '1 : r_q);

endmodule
`default_nettype wire

[hdl/hfv_lane.sv]
`default_nettype none
module hfv_lane (
    input  wire logic                          i_clk,
    input  wire hfv_pkg::t_lane_ctl            i_ctl,
    input  wire hfv_pkg::t_vec                 i_fwd,
    input  wire hfv_pkg::t_vec                 i_path,
    input  wire hfv_pkg::t_vec                 i_col,
    input  wire logic [hfv_pkg::PB-1:0]        i_lik,
    input  wire logic [hfv_pkg::SCALE_W-1:0]   i_scale,
    input  wire logic [hfv_pkg::SUM_W-1:0]     i_sum,
    output logic      [hfv_pkg::G_W-1:0]       o_g,
    output logic      [hfv_pkg::M_W-1:0]       o_m,
    output logic      [hfv_pkg::SW-1:0]        o_bi,
    output logic      [hfv_pkg::PB-1:0]        o_fwd,
    output logic      [hfv_pkg::PB-1:0]        o_path
);

    logic [hfv_pkg::BEST_W-1:0] w_pf [hfv_pkg::NS];
    logic [hfv_pkg::BEST_W-1:0] w_pp [hfv_pkg::NS];
    logic [hfv_pkg::ACC_W-1:0]  w_acc;
    logic [hfv_pkg::BEST_W-1:0] w_best;
    logic [hfv_pkg::SW-1:0]     w_bi;

    logic [hfv_pkg::ACC_W-1:0]  r_acc;
    logic [hfv_pkg::BEST_W-1:0] r_best;
    logic [hfv_pkg::SW-1:0]     r_bi;
    logic [hfv_pkg::G_W-1:0]    r_g;
    logic [hfv_pkg::M_W-1:0]    r_m;

    for (genvar i = 0; i < hfv_pkg::NS; i++) begin : g_prod
        assign w_pf[i] = i_fwd[i] * i_col[i];
        assign w_pp[i] = i_path[i] * i_col[i];
    end

    // prediction sum and best predecessor, lowest index wins ties
    always_comb begin
        w_acc  = '0;
        w_best = w_pp[0];
        w_bi   = '0;
        for (int i = 0; i < hfv_pkg::NS; i++) begin
            w_acc = w_acc + hfv_pkg::ACC_W'(w_pf[i]);
        end
        for (int i = 1; i < hfv_pkg::NS; i++) begin
            if (w_pp[i] > w_best) begin
                w_best = w_pp[i];
                w_bi   = hfv_pkg::SW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul1) begin
            r_acc  <= w_acc;
            r_best <= w_best;
            r_bi   <= w_bi;
        end
        if (i_ctl.mul2) begin
            r_g <= hfv_pkg::G_W'(i_lik) * hfv_pkg::G_W'(r_acc);
            r_m <= hfv_pkg::M_W'(r_best) * hfv_pkg::M_W'(i_lik);
        end
    end

    hfv_div #(.W(hfv_pkg::SCALE_W)) u_fdiv (
        .i_clk  (i_clk),
        .i_load (i_ctl.div_load),
        .i_step (i_ctl.div_step),
        .i_num  (hfv_pkg::SCALE_W'(r_g)),
        .i_den  (i_scale),
        .o_quot (o_fwd)
    );

    hfv_div #(.W(hfv_pkg::SUM_W)) u_pdiv (
        .i_clk  (i_clk),
        .i_load (i_ctl.div_load),
        .i_step (i_ctl.div_step),
        .i_num  (hfv_pkg::SUM_W'(r_m)),
        .i_den  (i_sum),
        .o_quot (o_path)
    );

    assign o_g  = r_g;
    assign o_m  = r_m;
    assign o_bi = r_bi;

endmodule
`default_nettype wire

[hdl/hmm_forward_filter_fixed_lag_viterbi_core.sv]
// an item passes the multiply, sum and load states and divides unless its scale is zero;
// with lag 1 or during warm-up no backtrack runs, else one follows through the back pointer
// ram; a new item is taken only in idle, once the last result is loaded for output, and the
// pace is set by the 16-bit lane dividers and the backtrack walk, one slot per cycle
// reset: synchronous active low, forward vector uniform, history empty, lag 1
`default_nettype none
module hmm_forward_filter_fixed_lag_viterbi_core #(
    parameter int HISTORY_DEPTH = hfv_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [hfv_pkg::PB-1:0]        i_lik_0,
    input  wire logic [hfv_pkg::PB-1:0]        i_lik_1,
    input  wire logic [hfv_pkg::PB-1:0]        i_lik_2,
    input  wire logic [hfv_pkg::PB-1:0]        i_lik_3,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [hfv_pkg::SW-1:0]             o_decoded_state,
    output logic                               o_state_valid,
    output logic                               o_zero_likelihood,
    output logic [hfv_pkg::SW-1:0]             o_filtered_state,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hfv_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [hfv_pkg::ROW_W-1:0]     pwdata,
    output logic      [hfv_pkg::ROW_W-1:0]     prdata,
    output logic                               pready
);

    localparam int SLW = $clog2(HISTORY_DEPTH);
    localparam int LW  = $clog2(HISTORY_DEPTH + 1);
    localparam logic [2:0] REG_LAG_IDX = hfv_pkg::REG_LAG;

    hfv_pkg::t_state                           r_state, n_state;
    hfv_pkg::t_lane_ctl                        w_ctl;
    logic [hfv_pkg::NS-1:0][hfv_pkg::ROW_W-1:0] r_trans;
    logic [4:0]                                r_lag;
    hfv_pkg::t_vec                             r_fwd;
    hfv_pkg::t_vec                             r_path;
    hfv_pkg::t_vec                             r_lik;
    logic [SLW-1:0]                            r_wslot;
    logic [SLW-1:0]                            r_fill;
    logic [hfv_pkg::SCALE_W-1:0]               r_scale;
    logic [hfv_pkg::SUM_W-1:0]                 r_msum;
    logic [hfv_pkg::CNT_W-1:0]                 r_cnt;
    logic [SLW-1:0]                            r_bt;
    logic [SLW-1:0]                            r_iss;
    logic [SLW-1:0]                            r_k;
    logic                                      r_rv;
    logic [hfv_pkg::SW-1:0]                    r_st;
    logic [hfv_pkg::SW-1:0]                    r_res_dec;
    logic                                      r_res_sv;
    logic                                      r_res_zero;
    logic [hfv_pkg::SW-1:0]                    r_res_filt;
    logic                                      r_ovalid;
    logic [hfv_pkg::SW-1:0]                    r_odec;
    logic                                      r_osv;
    logic                                      r_ozero;
    logic [hfv_pkg::SW-1:0]                    r_ofilt;

    logic [hfv_pkg::G_W-1:0]                   w_g  [hfv_pkg::NS];
    logic [hfv_pkg::M_W-1:0]                   w_m  [hfv_pkg::NS];
    logic [hfv_pkg::NS-1:0][hfv_pkg::SW-1:0]   w_bi;
    hfv_pkg::t_vec                             w_fwd_new;
    hfv_pkg::t_vec                             w_path_new;
    logic [hfv_pkg::SCALE_W-1:0]               w_scale;
    logic [hfv_pkg::SUM_W-1:0]                 w_msum;
    logic [hfv_pkg::SW-1:0]                    w_filt;
    logic [hfv_pkg::SW-1:0]                    w_pst;
    logic [7:0]                                w_lag8;
    logic [LW-1:0]                             w_lag_eff;
    logic [SLW-1:0]                            w_lag_m1;
    logic [SLW-1:0]                            w_wslot_nx;
    logic [SLW-1:0]                            w_bt_prev;
    logic [hfv_pkg::NS*hfv_pkg::SW-1:0]        w_rdata;
    logic [hfv_pkg::SW-1:0]                    w_bt_sel;
    logic                                      w_cfg_we;
    logic [2:0]                                w_cfg_idx;
    logic                                      w_in_xfer;
    logic                                      w_out_xfer;
    logic                                      w_bp_we;
    logic                                      w_out_load;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = r_ovalid && i_out_ready;
    assign w_cfg_we   = psel && penable && pwrite;
    assign w_cfg_idx  = paddr[hfv_pkg::ADDR_W-1:3];

    // effective lag, clamped to 1 .. history depth
    assign w_lag8    = {3'b000, r_lag};
    assign w_lag_eff = (w_lag8 == 8'd0) ? LW'(1) :
                       (w_lag8 > 8'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH) : LW'(w_lag8);
    assign w_lag_m1   = SLW'(w_lag_eff - LW'(1));
    assign w_wslot_nx = ((LW'(r_wslot) + LW'(1)) == w_lag_eff) ? '0 : r_wslot + SLW'(1);
    assign w_bt_prev  = (r_bt == '0) ? w_lag_m1 : r_bt - SLW'(1);

    for (genvar j = 0; j < hfv_pkg::NS; j++) begin : g_lane
        hfv_pkg::t_vec w_col;
        for (genvar i = 0; i < hfv_pkg::NS; i++) begin : g_col
            assign w_col[i] = r_trans[i][hfv_pkg::PB*j +: hfv_pkg::PB];
        end
        hfv_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_fwd   (r_fwd),
            .i_path  (r_path),
            .i_col   (w_col),
            .i_lik   (r_lik[j]),
            .i_scale (r_scale),
            .i_sum   (r_msum),
            .o_g     (w_g[j]),
            .o_m     (w_m[j]),
            .o_bi    (w_bi[j]),
            .o_fwd   (w_fwd_new[j]),
            .o_path  (w_path_new[j])
        );
    end

    // merge of lane results
    always_comb begin
        w_scale = '0;
        w_msum  = '0;
        for (int j = 0; j < hfv_pkg::NS; j++) begin
            w_scale = w_scale + hfv_pkg::SCALE_W'(w_g[j]);
            w_msum  = w_msum + hfv_pkg::SUM_W'(w_m[j]);
        end
    end

    assign w_filt   = hfv_pkg::argmax(w_fwd_new);
    assign w_pst    = hfv_pkg::argmax(w_path_new);
    assign w_bt_sel = w_rdata[hfv_pkg::SW*r_st +: hfv_pkg::SW];
    assign w_bp_we  = (r_state == hfv_pkg::S_UPD) && (w_lag_eff > LW'(1)) && (r_fill != '0);

    hfv_ram #(
        .WIDTH (hfv_pkg::NS * hfv_pkg::SW),
        .DEPTH (HISTORY_DEPTH)
    ) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (w_bp_we),
        .i_waddr (r_wslot),
        .i_wdata (w_bi),
        .i_raddr (r_bt),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hfv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_ctl      = '0;
        w_out_load = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            hfv_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = hfv_pkg::S_MUL1;
                end
            end
            hfv_pkg::S_MUL1: begin
                w_ctl.mul1 = 1'b1;
                n_state    = hfv_pkg::S_MUL2;
            end
            hfv_pkg::S_MUL2: begin
                w_ctl.mul2 = 1'b1;
                n_state    = hfv_pkg::S_SUM;
            end
            hfv_pkg::S_SUM: begin
                n_state = hfv_pkg::S_LOAD;
            end
            hfv_pkg::S_LOAD: begin
                w_ctl.div_load = 1'b1;
                n_state = (r_scale == '0) ? hfv_pkg::S_DONE : hfv_pkg::S_DIV;
            end
            hfv_pkg::S_DIV: begin
                w_ctl.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = hfv_pkg::S_UPD;
                end
            end
            hfv_pkg::S_UPD: begin
                if (w_lag_eff > LW'(1) && r_fill != '0
                        && !((LW'(r_fill) + LW'(1)) < w_lag_eff)) begin
                    n_state = hfv_pkg::S_BT;
                end else begin
                    n_state = hfv_pkg::S_DONE;
                end
            end
            hfv_pkg::S_BT: begin
                if (r_rv && r_k == SLW'(1)) begin
                    n_state = hfv_pkg::S_DONE;
                end
            end
            hfv_pkg::S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = hfv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hfv_pkg::S_IDLE;
            end
        endcase
    end

    // configuration, filter state and history control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hfv_pkg::NS; i++) begin
                r_trans[i] <= hfv_pkg::TRANS_RESET;
                r_fwd[i]   <= hfv_pkg::F_RESET;
            end
            r_lag   <= hfv_pkg::LAG_RESET;
            r_wslot <= '0;
            r_fill  <= '0;
        end else begin
            if (w_cfg_we) begin
                if (w_cfg_idx < REG_LAG_IDX) begin
                    r_trans[w_cfg_idx[hfv_pkg::SW-1:0]] <= pwdata;
                end else if (w_cfg_idx == REG_LAG_IDX && pwdata[4:0] != r_lag) begin
                    r_lag   <= pwdata[4:0];
                    r_wslot <= '0;
                    r_fill  <= '0;
                end
            end
            if (r_state == hfv_pkg::S_LOAD && r_scale == '0) begin
                for (int i = 0; i < hfv_pkg::NS; i++) begin
                    r_fwd[i] <= hfv_pkg::F_RESET;
                end
                r_wslot <= '0;
                r_fill  <= '0;
            end
            if (r_state == hfv_pkg::S_UPD) begin
                r_fwd <= w_fwd_new;
                if (w_lag_eff > LW'(1)) begin
                    r_wslot <= w_wslot_nx;
                    if (r_fill == '0) begin
                        r_fill <= SLW'(1);
                    end else if ((LW'(r_fill) + LW'(1)) < w_lag_eff) begin
                        r_fill <= r_fill + SLW'(1);
                    end
                end
            end
        end
    end

    // datapath and result registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_lik <= {i_lik_3, i_lik_2, i_lik_1, i_lik_0};
        end
        if (r_state == hfv_pkg::S_SUM) begin
            r_scale <= w_scale;
        end
        if (r_state == hfv_pkg::S_MUL2) begin
            r_cnt <= hfv_pkg::CNT_W'(hfv_pkg::PB - 1);
        end
        if (r_state == hfv_pkg::S_DIV) begin
            r_cnt <= r_cnt - hfv_pkg::CNT_W'(1);
        end
        if (r_state == hfv_pkg::S_SUM) begin
            r_msum <= w_msum;
        end
        if (r_state == hfv_pkg::S_LOAD) begin
            r_res_dec  <= '0;
            r_res_sv   <= 1'b0;
            r_res_zero <= (r_scale == '0);
            r_res_filt <= '0;
        end
        if (r_state == hfv_pkg::S_UPD) begin
            r_res_filt <= w_filt;
            if (w_lag_eff == LW'(1)) begin
                r_res_dec <= w_filt;
                r_res_sv  <= 1'b1;
            end else if (r_fill == '0) begin
                r_path <= w_fwd_new;
            end else begin
                r_path <= w_path_new;
                r_st   <= w_pst;
                r_bt   <= r_wslot;
                r_iss  <= w_lag_m1;
                r_k    <= w_lag_m1;
                r_rv   <= 1'b0;
            end
        end
        if (r_state == hfv_pkg::S_BT) begin
            r_rv <= (r_iss != '0);
            if (r_iss != '0) begin
                r_iss <= r_iss - SLW'(1);
                r_bt  <= w_bt_prev;
            end
            if (r_rv) begin
                r_st <= w_bt_sel;
                r_k  <= r_k - SLW'(1);
                if (r_k == SLW'(1)) begin
                    r_res_dec <= w_bt_sel;
                    r_res_sv  <= 1'b1;
                end
            end
        end
        if (w_out_load) begin
            r_odec  <= r_res_dec;
            r_osv   <= r_res_sv;
            r_ozero <= r_res_zero;
            r_ofilt <= r_res_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (w_out_xfer) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_decoded_state   = r_odec;
    assign o_state_valid     = r_osv;
    assign o_zero_likelihood = r_ozero;
    assign o_filtered_state  = r_ofilt;

    always_comb begin
        prdata = '0;
        if (w_cfg_idx < REG_LAG_IDX) begin
            prdata = r_trans[w_cfg_idx[hfv_pkg::SW-1:0]];
        end else if (w_cfg_idx == REG_LAG_IDX) begin
            prdata = hfv_pkg::ROW_W'(r_lag);
        end
    end

    assign pready = 1'b1;

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_wslot) < w_lag_eff)
        else $error("write slot beyond lag");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lag_eff > LW'(1)) |-> (LW'(r_fill) < w_lag_eff))
        else $error("fill count reached lag");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ozero) |-> (!r_osv && r_odec == '0 && r_ofilt == '0))
        else $error("zero likelihood result carries a state");

    a_invalid_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_osv) |-> (r_odec == '0))
        else $error("decoded state set while not valid");

endmodule
`default_nettype wire
